// File: rtl/core/pnme_pkg.sv
// pnme_pkg: types, codes and sizes shared by the paxos node message engine
// no dependencies; used by pnme_ctrl, pnme_dp and the top level
package pnme_pkg;

  localparam int unsigned SLOT_COUNT   = 256;
  localparam int unsigned NODE_ID_BITS = 16;
  localparam int unsigned SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam logic [63:0] NODE_MASK    = (64'd1 << NODE_ID_BITS) - 64'd1;

  typedef enum logic [2:0] {
    K_PROPOSE  = 3'd0,
    K_PREPARE  = 3'd1,
    K_PROMISE  = 3'd2,
    K_ACCEPT   = 3'd3,
    K_ACCEPTED = 3'd4,
    K_LEARN    = 3'd5,
    K_RELEASE  = 3'd6,
    K_UNUSED   = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    PH_NONE     = 3'd0,
    PH_PREPARE  = 3'd1,
    PH_PROMISE  = 3'd2,
    PH_ACCEPT   = 3'd3,
    PH_ACCEPTED = 3'd4,
    PH_LEARN    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_IGNORED = 2'd1,
    STS_NO_SLOT = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QUORUM_NEEDED = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EXEC = 2'd2
  } state_e;

  typedef struct packed {
    logic [63:0] proposal;
    logic [63:0] seq;
    logic [7:0]  promises;
    logic [7:0]  accepts;
  } slot_ent_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] msg_proposal_id;
    logic [63:0] msg_sequence;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  reply_phase;
    logic [63:0] reply_proposal_id;
    logic [63:0] reply_sequence;
    logic [63:0] reply_accepted_id;
    logic [7:0]  slot_used;
    logic        persist_strobe;
    logic        apply_strobe;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic scan_run;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic hit;
    logic miss;
    logic out_full;
  } stat_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

endpackage

// File: rtl/core/pnme_if.sv
// pnme interfaces: input item, result item and configuration write channels
// depends on nothing
interface pnme_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] msg_proposal_id;
  logic [63:0] msg_sequence;
  modport source (output valid, kind, msg_proposal_id, msg_sequence, input ready);
  modport sink   (input valid, kind, msg_proposal_id, msg_sequence, output ready);
endinterface

interface pnme_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reply_phase;
  logic [63:0] reply_proposal_id;
  logic [63:0] reply_sequence;
  logic [63:0] reply_accepted_id;
  logic [7:0]  slot_used;
  logic        persist_strobe;
  logic        apply_strobe;
  logic [1:0]  status;
  modport source (output valid, reply_phase, reply_proposal_id, reply_sequence,
                  reply_accepted_id, slot_used, persist_strobe, apply_strobe, status,
                  input ready);
  modport sink   (input valid, reply_phase, reply_proposal_id, reply_sequence,
                  reply_accepted_id, slot_used, persist_strobe, apply_strobe, status,
                  output ready);
endinterface

interface pnme_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/pnme_ram.sv
// pnme_ram: generic single write port, single read port ram with registered read
// no dependencies
module pnme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pnme_ctrl.sv
// pnme_ctrl: sequencing state machine of the message engine
// depends on pnme_pkg; drives commands to pnme_dp
module pnme_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pnme_pkg::stat_t  stat_i,
  output pnme_pkg::cmd_t   cmd_o
);

  pnme_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnme_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pnme_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = stat_i.needs_scan ? pnme_pkg::S_SCAN : pnme_pkg::S_EXEC;
        end
      end
      pnme_pkg::S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.hit || stat_i.miss) begin
          state_d = pnme_pkg::S_EXEC;
        end
      end
      pnme_pkg::S_EXEC: begin
        if (!stat_i.out_full) begin
          cmd_o.exec = 1'b1;
          state_d    = pnme_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pnme_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/pnme_dp.sv
// pnme_dp: acceptor, learner and proposer state, slot table, scan and result register
// depends on pnme_pkg and pnme_ram; controlled by pnme_ctrl
module pnme_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pnme_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pnme_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  pnme_pkg::in_item_t                in_item_i,
  input  pnme_pkg::cmd_t                    cmd_i,
  output pnme_pkg::stat_t                   stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pnme_pkg::out_item_t               out_item_o
);

  localparam int unsigned SW = pnme_pkg::SLOT_W;
  localparam int unsigned EW = $bits(pnme_pkg::slot_ent_t);

  logic [15:0] node_q;
  logic [7:0]  quorum_q;

  logic [63:0] hs_q, hs_d, la_q, la_d, hc_q, hc_d, hp_q, hp_d, nseq_q, nseq_d;
  logic [pnme_pkg::SLOT_COUNT-1:0] busy_q, done_q;

  logic [2:0]  kind_q;
  logic [63:0] id_q, seq_q;

  logic [SW:0]   idx_q;
  logic [SW-1:0] pidx_q, sidx_q;
  logic          pvalid_q, hit_q;
  pnme_pkg::slot_ent_t ent_q, rdata;
  logic          re, hit_c, issue;

  pnme_pkg::out_item_t out_q, o;
  logic        out_valid_q;

  pnme_pkg::slot_ent_t wdata;
  logic        we_c, busy_set, busy_clr, done_set, ba;
  logic [63:0] pid_new, ba_id, ba_seq;
  logic [7:0]  newc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q   <= '0;
      quorum_q <= 8'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pnme_pkg::CFG_OWN_NODE_ID) begin
        node_q <= cfg_data_i[15:0];
      end else if (cfg_idx_i == pnme_pkg::CFG_QUORUM_NEEDED) begin
        quorum_q <= cfg_data_i[7:0];
      end
    end
  end

  // slot scan: read slot idx while checking the slot read in the previous cycle
  assign issue = cmd_i.scan_run && (idx_q < (SW+1)'(pnme_pkg::SLOT_COUNT));
  assign re    = issue;

  always_comb begin
    hit_c = 1'b0;
    if (pvalid_q) begin
      if (pnme_pkg::kind_e'(kind_q) == pnme_pkg::K_PROPOSE) begin
        hit_c = !busy_q[pidx_q];
      end else if (pnme_pkg::kind_e'(kind_q) == pnme_pkg::K_RELEASE) begin
        hit_c = busy_q[pidx_q] && (rdata.proposal == id_q);
      end else begin
        hit_c = busy_q[pidx_q] && !done_q[pidx_q] && (rdata.proposal == id_q);
      end
    end
  end

  assign stat_o.needs_scan = (in_item_i.kind == pnme_pkg::K_PROPOSE) ||
                             (in_item_i.kind == pnme_pkg::K_PROMISE) ||
                             (in_item_i.kind == pnme_pkg::K_ACCEPTED) ||
                             (in_item_i.kind == pnme_pkg::K_RELEASE);
  assign stat_o.hit      = cmd_i.scan_run && hit_c;
  assign stat_o.miss     = cmd_i.scan_run && pvalid_q && !hit_c &&
                           (pidx_q == SW'(pnme_pkg::SLOT_COUNT - 1));
  assign stat_o.out_full = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      pvalid_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.take) begin
      idx_q    <= '0;
      pvalid_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.scan_run) begin
      if (issue) begin
        idx_q <= idx_q + (SW+1)'(1);
      end
      pvalid_q <= issue;
      if (hit_c) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= in_item_i.kind;
      id_q   <= in_item_i.msg_proposal_id;
      seq_q  <= in_item_i.msg_sequence;
    end
    if (issue) begin
      pidx_q <= idx_q[SW-1:0];
    end
    if (cmd_i.scan_run && hit_c) begin
      ent_q  <= rdata;
      sidx_q <= pidx_q;
    end
  end

  pnme_ram #(
    .WIDTH(EW),
    .DEPTH(pnme_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && we_c),
    .waddr_i(sidx_q),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(idx_q[SW-1:0]),
    .rdata_o(rdata)
  );

  // result and state update for the item
  always_comb begin
    o          = '0;
    o.status   = pnme_pkg::STS_IGNORED;
    hs_d       = hs_q;
    la_d       = la_q;
    hc_d       = hc_q;
    hp_d       = hp_q;
    nseq_d     = nseq_q;
    wdata      = ent_q;
    we_c       = 1'b0;
    busy_set   = 1'b0;
    busy_clr   = 1'b0;
    done_set   = 1'b0;
    ba         = 1'b0;
    ba_id      = ent_q.proposal;
    ba_seq     = ent_q.seq;
    newc       = 8'd0;
    pid_new    = ((hs_q + 64'd1) << pnme_pkg::NODE_ID_BITS) |
                 ({48'd0, node_q} & pnme_pkg::NODE_MASK);
    case (pnme_pkg::kind_e'(kind_q))
      pnme_pkg::K_PROPOSE: begin
        hs_d   = pid_new;
        nseq_d = nseq_q + 64'd1;
        if (!hit_q) begin
          o.status = pnme_pkg::STS_NO_SLOT;
        end else begin
          we_c           = 1'b1;
          wdata.proposal = pid_new;
          wdata.seq      = nseq_q;
          wdata.promises = 8'd1;
          wdata.accepts  = 8'd0;
          busy_set       = 1'b1;
          o.slot_used    = 8'(sidx_q);
          if (quorum_q <= 8'd1) begin
            ba     = 1'b1;
            ba_id  = pid_new;
            ba_seq = nseq_q;
          end else begin
            o.reply_phase       = pnme_pkg::PH_PREPARE;
            o.reply_proposal_id = pid_new;
            o.reply_sequence    = nseq_q;
            o.status            = pnme_pkg::STS_OK;
          end
        end
      end
      pnme_pkg::K_PREPARE: begin
        if (id_q > hs_q) begin
          hs_d                = id_q;
          o.reply_phase       = pnme_pkg::PH_PROMISE;
          o.reply_proposal_id = id_q;
          o.reply_sequence    = seq_q;
          o.reply_accepted_id = la_q;
          o.status            = pnme_pkg::STS_OK;
        end
      end
      pnme_pkg::K_PROMISE: begin
        if (hit_q) begin
          o.slot_used    = 8'(sidx_q);
          newc           = pnme_pkg::sat_inc(ent_q.promises);
          we_c           = 1'b1;
          wdata.promises = newc;
          if (ent_q.promises < quorum_q && newc >= quorum_q) begin
            ba = 1'b1;
          end
        end
      end
      pnme_pkg::K_ACCEPT: begin
        if (id_q >= hs_q) begin
          hs_d = id_q;
          la_d = id_q;
          if (seq_q > hp_q) begin
            hp_d             = seq_q;
            o.persist_strobe = 1'b1;
          end
          o.reply_phase       = pnme_pkg::PH_ACCEPTED;
          o.reply_proposal_id = id_q;
          o.reply_sequence    = seq_q;
          o.status            = pnme_pkg::STS_OK;
        end
      end
      pnme_pkg::K_ACCEPTED: begin
        if (hit_q) begin
          o.slot_used   = 8'(sidx_q);
          newc          = pnme_pkg::sat_inc(ent_q.accepts);
          we_c          = 1'b1;
          wdata.accepts = newc;
          if (newc >= quorum_q) begin
            done_set = 1'b1;
            if (ent_q.seq > hc_q) begin
              hc_d = ent_q.seq;
            end
            o.reply_phase       = pnme_pkg::PH_LEARN;
            o.reply_proposal_id = ent_q.proposal;
            o.reply_sequence    = ent_q.seq;
            o.reply_accepted_id = ent_q.proposal;
            o.apply_strobe      = 1'b1;
            o.status            = pnme_pkg::STS_OK;
          end
        end
      end
      pnme_pkg::K_LEARN: begin
        if (seq_q > hc_q) begin
          if (seq_q > hp_q) begin
            hp_d             = seq_q;
            o.persist_strobe = 1'b1;
          end
          hc_d                = seq_q;
          o.reply_proposal_id = id_q;
          o.reply_sequence    = seq_q;
          o.apply_strobe      = 1'b1;
          o.status            = pnme_pkg::STS_OK;
        end
      end
      pnme_pkg::K_RELEASE: begin
        if (hit_q) begin
          busy_clr    = 1'b1;
          o.slot_used = 8'(sidx_q);
          o.status    = pnme_pkg::STS_OK;
        end
      end
      default: begin
        o.status = pnme_pkg::STS_IGNORED;
      end
    endcase
    // start of the accept phase for the slot
    if (ba) begin
      if (ba_id >= hs_d) begin
        hs_d = ba_id;
        la_d = ba_id;
      end
      if (ba_seq > hp_d) begin
        hp_d = ba_seq;
      end
      wdata.accepts       = 8'd1;
      o.reply_phase       = pnme_pkg::PH_ACCEPT;
      o.reply_proposal_id = ba_id;
      o.reply_sequence    = ba_seq;
      o.reply_accepted_id = 64'd0;
      o.persist_strobe    = 1'b1;
      o.status            = pnme_pkg::STS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q        <= '0;
      la_q        <= '0;
      hc_q        <= '0;
      hp_q        <= '0;
      nseq_q      <= 64'd1;
      busy_q      <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        hs_q        <= hs_d;
        la_q        <= la_d;
        hc_q        <= hc_d;
        hp_q        <= hp_d;
        nseq_q      <= nseq_d;
        out_valid_q <= 1'b1;
        if (busy_set) begin
          busy_q[sidx_q] <= 1'b1;
          done_q[sidx_q] <= 1'b0;
        end
        if (busy_clr) begin
          busy_q[sidx_q] <= 1'b0;
          done_q[sidx_q] <= 1'b0;
        end
        if (done_set) begin
          done_q[sidx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= o;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/core/paxos_node_message_engine.sv
// Paxos node message engine: takes one message header per item and returns one
// result item. Prepare, accept, learn and the unused kind need no scan;
// propose, promise, accepted and release scan the slot table one slot per cycle
// through the slot ram read port, ending at the first matching slot or after
// the last slot. One item is processed at a time; the next item may be
// accepted while the previous result waits in the output register.
// Configuration writes are always accepted. Depends on pnme_pkg, pnme_if,
// pnme_ram, pnme_ctrl and pnme_dp.
module paxos_node_message_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  pnme_in_if.sink           in_i,
  pnme_out_if.source        out_o,
  pnme_cfg_if.sink          cfg_i
);

  pnme_pkg::cmd_t      cmd;
  pnme_pkg::stat_t     stat;
  pnme_pkg::in_item_t  in_item;
  pnme_pkg::out_item_t out_item;
  logic                out_valid;

  assign cfg_i.ready = 1'b1;

  assign in_item.kind            = in_i.kind;
  assign in_item.msg_proposal_id = in_i.msg_proposal_id;
  assign in_item.msg_sequence    = in_i.msg_sequence;

  pnme_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pnme_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .in_item_i  (in_item),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .out_item_o (out_item)
  );

  assign out_o.valid             = out_valid;
  assign out_o.reply_phase       = out_item.reply_phase;
  assign out_o.reply_proposal_id = out_item.reply_proposal_id;
  assign out_o.reply_sequence    = out_item.reply_sequence;
  assign out_o.reply_accepted_id = out_item.reply_accepted_id;
  assign out_o.slot_used         = out_item.slot_used;
  assign out_o.persist_strobe    = out_item.persist_strobe;
  assign out_o.apply_strobe      = out_item.apply_strobe;
  assign out_o.status            = out_item.status;

endmodule
